// ===== src/ggcc_pkg.sv =====
// ----------------------------------------------------------------------------
// ggcc_pkg
// Shared types and constants of the glyph cache controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ggcc_pkg;

	localparam logic [7:0]  CONTROL_LIMIT  = 8'h20;
	localparam logic [7:0]  DOUBLE_LEAD    = 8'h80;
	localparam logic [7:0]  GBK_LEAD_BASE  = 8'h81;
	localparam logic [7:0]  GBK_TRAIL_BASE = 8'h40;
	localparam logic [7:0]  GBK_ROW        = 8'hBF;
	localparam logic [19:0] SINGLE_TAG     = 20'h10000;
	localparam logic [19:0] CONTROL_TAG    = 20'h80000;
	localparam logic [21:0] OFFSET_MAX     = 22'h3FFFFF;

	localparam int TAG_W   = 17;
	localparam int SLOT_W  = 10;
	localparam int LANES   = 8;
	localparam int LANE_W  = $clog2(LANES);
	localparam int QDEPTH  = 2;

	localparam logic [5:0]  FONT_SIZE_RESET    = 6'd16;
	localparam logic [10:0] SLOTS_IN_USE_RESET = 11'd256;

	localparam logic REG_FONT_SIZE    = 1'b0;
	localparam logic REG_SLOTS_IN_USE = 1'b1;

	typedef enum logic [1:0] {
		KIND_CONTROL = 2'd0,
		KIND_SINGLE  = 2'd1,
		KIND_DOUBLE  = 2'd2,
		KIND_BAD     = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [19:0] code;
		logic [21:0] offset;
	} item_t;

	typedef struct packed {
		kind_t             kind;
		logic [SLOT_W-1:0] slot;
		logic              hit;
		logic [19:0]       code;
		logic [21:0]       offset;
	} result_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SEARCH,
		B_FILL,
		B_DONE
	} back_state_t;

endpackage

`default_nettype wire

// ===== src/ggcc_front.sv =====
// ----------------------------------------------------------------------------
// ggcc_front
// Classifies each character, forms its glyph code and its font ROM offset.
// ----------------------------------------------------------------------------
`default_nettype none

module ggcc_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire logic [7:0]     lead_byte,
	input  wire logic [7:0]     trail_byte,
	input  wire logic [5:0]     font_size,
	output logic                q_push,
	output ggcc_pkg::item_t     q_item,
	input  wire logic           q_full
);
	import ggcc_pkg::*;

	logic        accept;
	kind_t       kind_d;
	logic [19:0] code_d;
	logic [14:0] mul_a_d;
	logic [8:0]  mul_b_d;
	logic [6:0]  row;
	logic [7:0]  col;
	logic [14:0] dbl_code;
	logic [3:0]  bytes_per_row;
	logic [8:0]  dbl_factor;
	logic [6:0]  single_size;

	logic        valid_s1;
	kind_t       kind_s1;
	logic [19:0] code_s1;
	logic [14:0] mul_a_s1;
	logic [8:0]  mul_b_s1;
	logic [23:0] product;
	logic [21:0] offset;

	assign full   = valid_s1 & q_full;
	assign accept = push & ~full;

	always_comb begin
		if (lead_byte < CONTROL_LIMIT) begin
			kind_d = KIND_CONTROL;
		end else if (lead_byte > DOUBLE_LEAD && trail_byte < GBK_TRAIL_BASE) begin
			kind_d = KIND_BAD;
		end else if (lead_byte > DOUBLE_LEAD) begin
			kind_d = KIND_DOUBLE;
		end else begin
			kind_d = KIND_SINGLE;
		end
	end

	assign row           = 7'(lead_byte - GBK_LEAD_BASE);
	assign col           = trail_byte - GBK_TRAIL_BASE;
	assign dbl_code      = 15'(row) * 15'(GBK_ROW) + 15'(col);
	assign bytes_per_row = 4'((7'(font_size) + 7'd7) >> 3);
	assign dbl_factor    = {5'd0, bytes_per_row} * {3'd0, font_size};
	assign single_size   = (font_size <= 6'd16) ? {1'b0, font_size} : {font_size, 1'b0};

	always_comb begin
		unique case (kind_d)
			KIND_CONTROL: begin
				code_d  = CONTROL_TAG | 20'(lead_byte);
				mul_a_d = '0;
				mul_b_d = '0;
			end
			KIND_SINGLE: begin
				code_d  = SINGLE_TAG | 20'(lead_byte);
				mul_a_d = 15'(lead_byte);
				mul_b_d = 9'(single_size);
			end
			KIND_DOUBLE: begin
				code_d  = 20'(dbl_code);
				mul_a_d = dbl_code;
				mul_b_d = dbl_factor;
			end
			default: begin
				code_d  = '0;
				mul_a_d = '0;
				mul_b_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind_d;
			code_s1  <= code_d;
			mul_a_s1 <= mul_a_d;
			mul_b_s1 <= mul_b_d;
		end
	end

	assign product = 24'(mul_a_s1) * 24'(mul_b_s1);
	assign offset  = (product > 24'(OFFSET_MAX)) ? OFFSET_MAX : product[21:0];

	assign q_push = valid_s1 & ~q_full;
	assign q_item = '{kind: kind_s1, code: code_s1, offset: offset};

endmodule

`default_nettype wire

// ===== src/ggcc_queue.sv =====
// ----------------------------------------------------------------------------
// ggcc_queue
// Short request queue between the classifier and the cache lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module ggcc_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire ggcc_pkg::item_t  wr_item,
	output logic                  full,
	input  wire logic             rd_en,
	output ggcc_pkg::item_t       rd_item,
	output logic                  empty
);
	import ggcc_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	item_t            entry_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(QDEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

`default_nettype wire

// ===== src/ggcc_back.sv =====
// ----------------------------------------------------------------------------
// ggcc_back
// Searches the tag store eight slots per cycle, fills on a miss with
// round-robin replacement, and holds the result for the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module ggcc_back #(
	parameter int SLOTS = 256
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [10:0]      slots_in_use,
	input  wire logic             q_empty,
	input  wire ggcc_pkg::item_t  q_item,
	output logic                  q_pop,
	output logic                  empty,
	input  wire logic             pop,
	output ggcc_pkg::result_t     result
);
	import ggcc_pkg::*;

	localparam int SW    = $clog2(SLOTS);
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int ROWS  = (SLOTS + LANES - 1) / LANES;
	localparam int ROW_W = $clog2(ROWS);
	localparam int XW    = ROW_W + 1 + LANE_W;

	back_state_t      state_q;
	back_state_t      state_d;
	item_t            cur_q;
	logic [SW-1:0]    ptr_q;
	logic [CW-1:0]    hw_q;
	logic [ROW_W:0]   rd_row_q;
	logic [ROW_W:0]   cmp_row_s1;
	logic             cmp_valid_s1;
	logic [SW-1:0]    res_slot_q;
	logic             res_hit_q;
	logic             out_valid_q;
	result_t          out_q;

	logic [CW-1:0]     n_eff;
	logic [CW-1:0]     lim;
	logic [XW-1:0]     lim_x;
	logic              issue_more;
	logic              rd_en;
	logic              wr_en;
	logic              out_load;
	logic              pop_acc;
	logic [LANES-1:0]  match;
	logic              hit_now;
	logic [LANE_W-1:0] hit_lane;
	logic [XW-1:0]     hit_idx;
	logic [SW-1:0]     fill_slot;
	logic [CW-1:0]     fill_next;
	logic [ROW_W-1:0]  wr_row;
	logic [LANE_W-1:0] wr_lane;

	always_comb begin
		if (slots_in_use == '0) begin
			n_eff = CW'(1);
		end else if (slots_in_use > 11'(SLOTS)) begin
			n_eff = CW'(SLOTS);
		end else begin
			n_eff = CW'(slots_in_use);
		end
	end

	assign lim        = (hw_q < n_eff) ? hw_q : n_eff;
	assign lim_x      = XW'(lim);
	assign issue_more = ({rd_row_q, LANE_W'(0)} < lim_x);
	assign pop_acc    = pop & out_valid_q;

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		logic [TAG_W-1:0] mem [ROWS];
		logic [TAG_W-1:0] rd_tag_s1;
		logic [XW-1:0]    idx;

		always_ff @(posedge clk) begin
			if (wr_en && wr_lane == LANE_W'(g)) begin
				mem[wr_row] <= cur_q.code[TAG_W-1:0];
			end
			if (rd_en) begin
				rd_tag_s1 <= mem[rd_row_q[ROW_W-1:0]];
			end
		end

		assign idx      = {cmp_row_s1, LANE_W'(g)};
		assign match[g] = (idx < lim_x) && (rd_tag_s1 == cur_q.code[TAG_W-1:0]);
	end

	always_comb begin
		hit_lane = '0;
		for (int l = LANES - 1; l >= 0; l--) begin
			if (match[l]) begin
				hit_lane = LANE_W'(l);
			end
		end
	end

	assign hit_now = |match;
	assign hit_idx = {cmp_row_s1, hit_lane};

	assign fill_slot = (CW'(ptr_q) < n_eff) ? ptr_q : '0;
	assign fill_next = CW'(fill_slot) + CW'(1);
	assign wr_row    = ROW_W'(fill_slot >> LANE_W);
	assign wr_lane   = fill_slot[LANE_W-1:0];

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (q_item.kind inside {KIND_SINGLE, KIND_DOUBLE}) begin
						state_d = B_SEARCH;
					end else begin
						state_d = B_DONE;
					end
				end
			end
			B_SEARCH: begin
				if (cmp_valid_s1 && hit_now) begin
					state_d = B_DONE;
				end else if (issue_more) begin
					rd_en = 1'b1;
				end else if (!cmp_valid_s1) begin
					state_d = B_FILL;
				end
			end
			B_FILL: begin
				wr_en   = 1'b1;
				state_d = B_DONE;
			end
			B_DONE: begin
				if (!out_valid_q || pop_acc) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			hw_q         <= '0;
			rd_row_q     <= '0;
			cmp_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			cmp_valid_s1 <= rd_en;
			if (q_pop) begin
				rd_row_q <= '0;
			end else if (rd_en) begin
				rd_row_q <= rd_row_q + 1'b1;
			end
			if (wr_en) begin
				ptr_q <= (fill_next >= n_eff) ? '0 : SW'(fill_next);
				if (fill_next > hw_q) begin
					hw_q <= fill_next;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q      <= q_item;
			res_slot_q <= '0;
			res_hit_q  <= 1'b0;
		end else if (state_q == B_SEARCH && cmp_valid_s1 && hit_now) begin
			res_slot_q <= SW'(hit_idx);
			res_hit_q  <= 1'b1;
		end else if (wr_en) begin
			res_slot_q <= fill_slot;
			res_hit_q  <= 1'b0;
		end
		if (rd_en) begin
			cmp_row_s1 <= rd_row_q;
		end
		if (out_load) begin
			out_q.kind   <= cur_q.kind;
			out_q.slot   <= SLOT_W'(res_slot_q);
			out_q.hit    <= res_hit_q;
			out_q.code   <= cur_q.code;
			out_q.offset <= res_hit_q ? '0 : cur_q.offset;
		end
	end

	assign empty  = ~out_valid_q;
	assign result = out_q;

	a_hw_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		hw_q >= $past(hw_q))
		else $error("Filled-slot mark decreased.");

	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_FILL) |-> (CW'(fill_slot) < n_eff))
		else $error("Fill slot outside the active slot range.");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_SEARCH && cmp_valid_s1 && hit_now) |-> (hit_idx < lim_x))
		else $error("Hit reported on a slot that was never filled or is inactive.");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("Loaded result is not presented.");

endmodule

`default_nettype wire

// ===== src/gbk_glyph_cache_controller.sv =====
// ----------------------------------------------------------------------------
// gbk_glyph_cache_controller
// Classifies GBK characters and manages a fully associative glyph slot cache.
// ----------------------------------------------------------------------------
// Characters enter through push/full as a lead byte and a trail byte. Each
// request yields one result through empty/pop: the character kind, the cache
// slot, a hit flag, the glyph code and the font ROM offset for a miss fill.
// The APB port holds font_size at address 0 and slots_in_use at address 4;
// write them only while no request is in flight.
// Control codes and bad trail bytes skip the search. A lookup reads eight
// tags per cycle from the tag memory over L = min(slots_in_use, slots filled
// so far) slots; a hit ends the search at its tag row, a miss searches the
// L slots and then fills one. Requests are looked up one at a time, while
// the classifier and a two-entry queue accept new characters.
// Reset empties the cache, points replacement at slot 0 and loads font_size 16
// and slots_in_use 256. When the receiver stalls, the finished result waits
// on the ports, the lookup holds its next result, and full rises once the
// queue and the classifier are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module gbk_glyph_cache_controller #(
	parameter int SLOTS = 256
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  wire logic         push,
	output logic              full,
	input  wire logic [7:0]   lead_byte,
	input  wire logic [7:0]   trail_byte,
	output logic              empty,
	input  wire logic         pop,
	output logic [1:0]        char_kind,
	output logic [9:0]        slot,
	output logic              hit,
	output logic [19:0]       glyph_code,
	output logic [21:0]       font_offset
);
	import ggcc_pkg::*;

	logic [5:0]  font_size_q;
	logic [10:0] slots_in_use_q;
	logic        reg_wr;
	logic        q_push;
	logic        q_full;
	logic        q_pop;
	logic        q_empty;
	item_t       push_item;
	item_t       pop_item;
	result_t     result;

	assign pready = 1'b1;
	assign reg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_size_q    <= FONT_SIZE_RESET;
			slots_in_use_q <= SLOTS_IN_USE_RESET;
		end else if (reg_wr) begin
			unique case (paddr[2])
				REG_FONT_SIZE:    font_size_q    <= pwdata[5:0];
				REG_SLOTS_IN_USE: slots_in_use_q <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FONT_SIZE:    prdata = 32'(font_size_q);
			REG_SLOTS_IN_USE: prdata = 32'(slots_in_use_q);
			default:          prdata = '0;
		endcase
	end

	ggcc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.lead_byte  (lead_byte),
		.trail_byte (trail_byte),
		.font_size  (font_size_q),
		.q_push     (q_push),
		.q_item     (push_item),
		.q_full     (q_full)
	);

	ggcc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_item (push_item),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_item (pop_item),
		.empty   (q_empty)
	);

	ggcc_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.slots_in_use (slots_in_use_q),
		.q_empty      (q_empty),
		.q_item       (pop_item),
		.q_pop        (q_pop),
		.empty        (empty),
		.pop          (pop),
		.result       (result)
	);

	assign char_kind   = result.kind;
	assign slot        = result.slot;
	assign hit         = result.hit;
	assign glyph_code  = result.code;
	assign font_offset = result.offset;

endmodule

`default_nettype wire

// ===== bench/glyph_cache_checker.sv =====
// ----------------------------------------------------------------------------
// glyph_cache_checker
// Watches the request, result and register channels of the glyph cache
// controller. It keeps its own copy of the tag store, the valid bits, the
// replacement pointer and both registers, works out the result of every
// accepted request, and compares each accepted result field by field with
// the oldest expected one.
// ----------------------------------------------------------------------------
module glyph_cache_checker #(
	parameter int SLOTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  lead_byte,
	input  logic [7:0]  trail_byte,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  char_kind,
	input  logic [9:0]  slot,
	input  logic        hit,
	input  logic [19:0] glyph_code,
	input  logic [21:0] font_offset,
	output int          errors,
	output int          outstanding
);
	import ggcc_pkg::*;

	localparam logic [2:0] ADDR_FONT_SIZE    = {REG_FONT_SIZE, 2'b00};
	localparam logic [2:0] ADDR_SLOTS_IN_USE = {REG_SLOTS_IN_USE, 2'b00};

	logic [TAG_W-1:0]  tags [SLOTS];
	bit                valid_bits [SLOTS];
	logic [SLOT_W-1:0] fill_ptr = '0;
	logic [5:0]        font_size = FONT_SIZE_RESET;
	logic [10:0]       slots_in_use = SLOTS_IN_USE_RESET;
	result_t           expected_glyphs [$];
	result_t           seen;
	result_t           want;
	int                fail_count = 0;

	initial begin
		errors = 0;
		outstanding = 0;
		foreach (valid_bits[k]) valid_bits[k] = 1'b0;
	end

	function automatic result_t lookup_glyph(input logic [7:0] lead, input logic [7:0] trail);
		result_t         r;
		longint unsigned raw;
		int unsigned     fs;
		int unsigned     n;
		int unsigned     i;
		int unsigned     glyph;
		bit              found;
		r = '0;
		raw = 0;
		found = 1'b0;
		fs = font_size;
		if (lead < CONTROL_LIMIT) begin
			r.kind = KIND_CONTROL;
			r.code = CONTROL_TAG | {12'd0, lead};
		end else if (lead > DOUBLE_LEAD && trail < GBK_TRAIL_BASE) begin
			r.kind = KIND_BAD;
		end else begin
			if (lead > DOUBLE_LEAD) begin
				r.kind = KIND_DOUBLE;
				glyph = (lead - GBK_LEAD_BASE) * GBK_ROW + (trail - GBK_TRAIL_BASE);
				r.code = glyph[19:0];
				raw = longint'(glyph) * longint'(((fs + 7) / 8) * fs);
			end else begin
				r.kind = KIND_SINGLE;
				r.code = SINGLE_TAG | {12'd0, lead};
				raw = longint'(lead) * longint'(fs <= 16 ? fs : 2 * fs);
			end
			n = slots_in_use;
			if (n < 1) n = 1;
			if (n > SLOTS) n = SLOTS;
			for (i = 0; i < n && !found; i++) begin
				if (valid_bits[i] && tags[i] == r.code[TAG_W-1:0]) begin
					found = 1'b1;
					r.slot = i[SLOT_W-1:0];
				end
			end
			if (found) begin
				r.hit = 1'b1;
			end else begin
				// A pointer left beyond a reduced slot count restarts at slot zero.
				r.slot = (fill_ptr < n) ? fill_ptr : '0;
				tags[r.slot] = r.code[TAG_W-1:0];
				valid_bits[r.slot] = 1'b1;
				fill_ptr = (r.slot + 1 >= n) ? '0 : r.slot + 1'b1;
				r.offset = (raw > OFFSET_MAX) ? OFFSET_MAX : raw[21:0];
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			foreach (valid_bits[k]) valid_bits[k] = 1'b0;
			fill_ptr = '0;
			font_size = FONT_SIZE_RESET;
			slots_in_use = SLOTS_IN_USE_RESET;
			expected_glyphs.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					ADDR_FONT_SIZE: font_size = pwdata[5:0];
					ADDR_SLOTS_IN_USE: slots_in_use = pwdata[10:0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				seen.kind = kind_t'(char_kind);
				seen.slot = slot;
				seen.hit = hit;
				seen.code = glyph_code;
				seen.offset = font_offset;
				if (expected_glyphs.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: kind %0d slot %0d hit %0d code %h offset %h",
							seen.kind, seen.slot, seen.hit, seen.code, seen.offset);
				end else begin
					want = expected_glyphs.pop_front();
					if (seen !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$write("mismatch: expected kind %0d slot %0d hit %0d code %h offset %h,",
								want.kind, want.slot, want.hit, want.code, want.offset);
							$display(" got kind %0d slot %0d hit %0d code %h offset %h",
								seen.kind, seen.slot, seen.hit, seen.code, seen.offset);
						end
					end
				end
			end
			if (push && !full)
				expected_glyphs.push_back(lookup_glyph(lead_byte, trail_byte));
		end
		outstanding <= expected_glyphs.size();
		errors <= fail_count;
	end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench top for the glyph cache controller.
// Resets the block, sends a directed set of character requests, then runs
// phases of random requests under several register settings, with the sender
// and the receiver stalling at different rates. A checker beside the block
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

	import ggcc_pkg::*;

	localparam int SLOTS       = 256;
	localparam int LIMIT       = 1000000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 100;
	localparam int POOL        = 32;
	localparam int DIRECTED    = 16;

	localparam logic [2:0] ADDR_FONT_SIZE    = {REG_FONT_SIZE, 2'b00};
	localparam logic [2:0] ADDR_SLOTS_IN_USE = {REG_SLOTS_IN_USE, 2'b00};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic        push = 1'b0;
	logic [7:0]  lead_byte = '0;
	logic [7:0]  trail_byte = '0;
	logic        pop = 1'b0;

	logic [31:0] prdata;
	logic        pready;
	logic        full;
	logic        empty;
	logic [1:0]  char_kind;
	logic [9:0]  slot;
	logic        hit;
	logic [19:0] glyph_code;
	logic [21:0] font_offset;

	int errors;
	int outstanding;
	int cycles = 0;
	int send_idle = 18;
	int recv_idle = 88;

	logic [7:0] pool_lead [POOL];
	logic [7:0] pool_trail [POOL];

	logic [7:0] dir_lead [DIRECTED] = '{8'h00, 8'h1F, 8'h20, 8'h7F, 8'h80, 8'h81, 8'h81, 8'hFF,
		8'hFE, 8'hFF, 8'h81, 8'h82, 8'h20, 8'h81, 8'h80, 8'hC5};
	logic [7:0] dir_trail [DIRECTED] = '{8'h00, 8'hFF, 8'h00, 8'h55, 8'h3F, 8'h40, 8'h3F, 8'h00,
		8'hFF, 8'hFF, 8'hFF, 8'h40, 8'hAA, 8'h40, 8'h00, 8'h3F};

	int phase_font [PHASES] = '{8, 32, 63, 0, 16, 24, 9, 17};
	int phase_slots [PHASES] = '{16, 1024, 1, 2047, 0, 64, 5, 200};

	gbk_glyph_cache_controller #(.SLOTS(SLOTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.push(push), .full(full), .lead_byte(lead_byte), .trail_byte(trail_byte),
		.empty(empty), .pop(pop),
		.char_kind(char_kind), .slot(slot), .hit(hit), .glyph_code(glyph_code),
		.font_offset(font_offset)
	);

	glyph_cache_checker #(.SLOTS(SLOTS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.pready(pready),
		.push(push), .full(full), .lead_byte(lead_byte), .trail_byte(trail_byte),
		.empty(empty), .pop(pop),
		.char_kind(char_kind), .slot(slot), .hit(hit), .glyph_code(glyph_code),
		.font_offset(font_offset),
		.errors(errors), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n)
			pop <= 1'b0;
		else
			pop <= ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_char(input logic [7:0] lead, input logic [7:0] trail);
		while ($urandom_range(0, 99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		lead_byte <= lead;
		trail_byte <= trail;
		do @(posedge clk); while (full);
	endtask

	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_config(input logic [5:0] fs, input logic [10:0] count);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_FONT_SIZE;
		pwdata <= {26'd0, fs};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penable <= 1'b0;
		paddr <= ADDR_SLOTS_IN_USE;
		pwdata <= {21'd0, count};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic fill_pool();
		for (int k = 0; k < POOL; k++) begin
			pool_lead[k] = 8'($urandom_range(8'h20, 8'hFF));
			pool_trail[k] = (pool_lead[k] > DOUBLE_LEAD) ? 8'($urandom_range(8'h40, 8'hFF))
				: 8'($urandom);
		end
	endtask

	task automatic pick_char(output logic [7:0] lead, output logic [7:0] trail);
		int roll;
		int k;
		roll = $urandom_range(0, 99);
		k = $urandom_range(0, POOL - 1);
		if (roll < 10) begin
			lead = 8'($urandom_range(0, 8'h1F));
			trail = 8'($urandom);
		end else if (roll < 18) begin
			lead = 8'($urandom_range(8'h81, 8'hFF));
			trail = 8'($urandom_range(0, 8'h3F));
		end else if (roll < 65) begin
			lead = pool_lead[k];
			trail = pool_trail[k];
		end else begin
			lead = 8'($urandom);
			trail = 8'($urandom);
		end
	endtask

	initial begin
		logic [7:0] lead;
		logic [7:0] trail;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		for (int d = 0; d < DIRECTED; d++)
			send_char(dir_lead[d], dir_trail[d]);
		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_config(6'(phase_font[p]), 11'(phase_slots[p]));
			if (p < 2) begin
				send_idle = 18;
				recv_idle = 88;
			end else if (p < 5) begin
				send_idle = 88;
				recv_idle = 18;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			fill_pool();
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pick_char(lead, trail);
				send_char(lead, trail);
			end
		end
		drain();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/ggcc_pkg.sv
src/ggcc_front.sv
src/ggcc_queue.sv
src/ggcc_back.sv
src/gbk_glyph_cache_controller.sv
bench/glyph_cache_checker.sv
bench/tb.sv
